>>> src/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and byte transforms for the block cipher core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int KEY_STORE_WORDS = 60;
  localparam int ROUND_W = 4;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_ENC = 2'd1,
    CMD_DEC = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [ROUND_W-1:0] ROUNDS_MIN = 4'd10;
  localparam logic [ROUND_W-1:0] ROUNDS_MAX = 4'd14;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] x;
    logic [7:0] p;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic logic [7:0] gf_mul8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] p;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul8 = p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    r = 8'h01;
    base = a;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul8(r, base);
      base = gf_mul8(base, base);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] v);
    logic [7:0] b;
    b = gf_inv(v);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [255:0][7:0] build_sbox(input logic inv);
    logic [255:0][7:0] t;
    logic [7:0] s;
    for (int i = 0; i < 256; i++) begin
      s = sbox_calc(8'(i));
      if (inv) t[s] = 8'(i);
      else t[i] = s;
    end
    build_sbox = t;
  endfunction

  localparam logic [255:0][7:0] SBOX = build_sbox(1'b0);
  localparam logic [255:0][7:0] INV_SBOX = build_sbox(1'b1);

endpackage

>>> src/aes_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// One shared cipher round: substitution, row shift, optional column mix
// and round key addition, for both directions.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic [3:0][31:0] state_i,
  input  logic [3:0][31:0] key_i,
  input  logic             inverse_i,
  input  logic             do_mix_i,
  output logic [3:0][31:0] state_o
);

  logic [3:0][3:0][7:0] sb;
  logic [3:0][3:0][7:0] mx;
  logic [7:0] a0, a1, a2, a3;
  int src;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inverse_i ? ((c + 4 - r) & 3) : ((c + r) & 3);
        sb[c][r] = inverse_i ? aes_pkg::INV_SBOX[state_i[src][8*r +: 8]]
                             : aes_pkg::SBOX[state_i[src][8*r +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[c][0]; a1 = sb[c][1]; a2 = sb[c][2]; a3 = sb[c][3];
      if (!inverse_i) begin
        mx[c][0] = aes_pkg::gf_mul(a0, 4'd2) ^ aes_pkg::gf_mul(a1, 4'd3) ^ a2 ^ a3;
        mx[c][1] = a0 ^ aes_pkg::gf_mul(a1, 4'd2) ^ aes_pkg::gf_mul(a2, 4'd3) ^ a3;
        mx[c][2] = a0 ^ a1 ^ aes_pkg::gf_mul(a2, 4'd2) ^ aes_pkg::gf_mul(a3, 4'd3);
        mx[c][3] = aes_pkg::gf_mul(a0, 4'd3) ^ a1 ^ a2 ^ aes_pkg::gf_mul(a3, 4'd2);
      end else begin
        mx[c][0] = aes_pkg::gf_mul(a0, 4'd14) ^ aes_pkg::gf_mul(a1, 4'd11)
                 ^ aes_pkg::gf_mul(a2, 4'd13) ^ aes_pkg::gf_mul(a3, 4'd9);
        mx[c][1] = aes_pkg::gf_mul(a0, 4'd9) ^ aes_pkg::gf_mul(a1, 4'd14)
                 ^ aes_pkg::gf_mul(a2, 4'd11) ^ aes_pkg::gf_mul(a3, 4'd13);
        mx[c][2] = aes_pkg::gf_mul(a0, 4'd13) ^ aes_pkg::gf_mul(a1, 4'd9)
                 ^ aes_pkg::gf_mul(a2, 4'd14) ^ aes_pkg::gf_mul(a3, 4'd11);
        mx[c][3] = aes_pkg::gf_mul(a0, 4'd11) ^ aes_pkg::gf_mul(a1, 4'd13)
                 ^ aes_pkg::gf_mul(a2, 4'd9) ^ aes_pkg::gf_mul(a3, 4'd14);
      end
      state_o[c] = (do_mix_i ? mx[c] : sb[c]) ^ key_i[c];
    end
  end

endmodule

>>> src/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// AES block cipher over four 32-bit columns with a 60-word round key store.
// The round keys sit in a memory with a registered read, read one round
// (four words) per cycle, and one shared round unit runs one round per
// cycle after the initial key addition.
// Decryption expects keys in equivalent inverse cipher form.
// ----------------------------------------------------------------------------
module aes_block_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_num_rounds,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [31:0] in_block_word0,
  input  logic [31:0] in_block_word1,
  input  logic [31:0] in_block_word2,
  input  logic [31:0] in_block_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word0,
  output logic [31:0] out_word1,
  output logic [31:0] out_word2,
  output logic [31:0] out_word3
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_ROUND
  } state_t;

  localparam int ROWS = aes_pkg::KEY_STORE_WORDS / 4;
  localparam int ROW_AW = 4;

  // round key memory, one row of four words per round
  logic [3:0][31:0] key_mem [ROWS];
  logic [3:0][31:0] key_rd_r;

  state_t                       state_r;
  logic [3:0]                   nr_r;
  logic [3:0]                   rnd_r;
  logic [3:0]                   last_r;
  logic                         inv_r;
  logic [3:0][31:0]             blk_r;
  logic [3:0][31:0]             res_r;
  logic                         res_vld_r;
  logic [ROW_AW-1:0]            rd_row;
  logic [3:0][31:0]             rnd_out;
  logic                         start;
  logic                         key_wr;
  logic                         do_mix;
  logic [3:0]                   nr_clamp;

  assign nr_clamp = (nr_r < aes_pkg::ROUNDS_MIN) ? aes_pkg::ROUNDS_MIN :
                    (nr_r > aes_pkg::ROUNDS_MAX) ? aes_pkg::ROUNDS_MAX : nr_r;

  assign in_ready = (state_r == ST_IDLE) && !res_vld_r;
  assign start = in_valid && in_ready &&
                 (in_cmd == aes_pkg::CMD_ENC || in_cmd == aes_pkg::CMD_DEC);
  assign key_wr = in_valid && in_ready && in_cmd == aes_pkg::CMD_KEY &&
                  in_key_index < 6'(aes_pkg::KEY_STORE_WORDS);

  // final round skips the column mix
  assign do_mix = (rnd_r + 4'd1) != last_r;

  // row index requested for the next cycle
  always_comb begin
    if (start) rd_row = (in_cmd == aes_pkg::CMD_DEC) ? nr_clamp : '0;
    else if (state_r == ST_FIRST) rd_row = inv_r ? last_r - 4'd1 : 4'd1;
    else if (state_r == ST_ROUND && do_mix)
      rd_row = inv_r ? last_r - rnd_r - 4'd2 : rnd_r + 4'd2;
    else rd_row = '0;
  end

  always_ff @(posedge clk) begin
    if (key_wr) key_mem[in_key_index[5:2]][in_key_index[1:0]] <= in_key_word;
    key_rd_r <= key_mem[rd_row];
  end

  aes_round u_round (
    .state_i   (blk_r),
    .key_i     (key_rd_r),
    .inverse_i (inv_r),
    .do_mix_i  (do_mix),
    .state_o   (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      nr_r      <= aes_pkg::ROUNDS_MIN;
      res_vld_r <= 1'b0;
      rnd_r     <= '0;
      last_r    <= aes_pkg::ROUNDS_MIN;
      inv_r     <= 1'b0;
    end else begin
      if (cfg_we) nr_r <= cfg_num_rounds;
      if (out_valid && out_ready) res_vld_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            blk_r   <= {in_block_word3, in_block_word2, in_block_word1, in_block_word0};
            inv_r   <= (in_cmd == aes_pkg::CMD_DEC);
            last_r  <= nr_clamp;
            rnd_r   <= '0;
            state_r <= ST_FIRST;
          end
        end
        ST_FIRST: begin
          blk_r   <= blk_r ^ key_rd_r;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          blk_r <= rnd_out;
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r + 4'd1 == last_r) begin
            res_r     <= rnd_out;
            res_vld_r <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // round counter runs 0..last_r-1 in ST_ROUND; stage key row follows
  assign out_valid = res_vld_r;
  assign out_word0 = res_r[0];
  assign out_word1 = res_r[1];
  assign out_word2 = res_r[2];
  assign out_word3 = res_r[3];

endmodule

>>> src/aes_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_core_checker
// Port level checks for the block cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module aes_core_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word0
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word0))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == aes_pkg::CMD_ENC || in_cmd == aes_pkg::CMD_DEC)
    |=> !in_ready)
    else $error("accepted block while busy");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == aes_pkg::CMD_ENC || in_cmd == aes_pkg::CMD_DEC)
    |=> ##1 !out_valid)
    else $error("result too early");

  a_key_nores: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == aes_pkg::CMD_KEY || in_cmd == aes_pkg::CMD_NOP)
    |=> !out_valid)
    else $error("result from key write");

endmodule

bind aes_block_cipher_core aes_core_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word0 (out_word0)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for aes_block_cipher_core. Loads the round key store,
// then runs encrypt, decrypt, key write and unused words under round counts
// 10 to 14 and out-of-range settings, with random gaps on both channels and
// one long output stall. Every result block is checked against an in-bench
// cipher model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [3:0][31:0] block_t;

  class block_predictor;
    logic [7:0] fwd_tbl [256];
    logic [7:0] rev_tbl [256];
    logic [31:0] key_mem [aes_pkg::KEY_STORE_WORDS];
    logic [3:0] rounds;
    block_t expected_blocks [$];
    int errors;
    int checked;

    function new();
      logic [7:0] b;
      logic [7:0] inv;
      for (int a = 0; a < 256; a++) begin
        inv = 8'h00;
        for (int x = 1; x < 256; x++)
          if (gmul(8'(a), 8'(x)) == 8'h01) inv = 8'(x);
        b = inv;
        fwd_tbl[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                     ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
      for (int a = 0; a < 256; a++) rev_tbl[fwd_tbl[a]] = 8'(a);
      for (int i = 0; i < aes_pkg::KEY_STORE_WORDS; i++) key_mem[i] = '0;
      rounds = 4'd10;
      errors = 0;
      checked = 0;
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] x;
      logic [7:0] p;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p ^= x;
        x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return p;
    endfunction

    function block_t sub_shift(block_t s, bit inv);
      block_t t;
      int src;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
          t[c][8*r +: 8] = inv ? rev_tbl[s[src][8*r +: 8]] : fwd_tbl[s[src][8*r +: 8]];
        end
      return t;
    endfunction

    function block_t mix(block_t s, bit inv);
      block_t t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
        a0 = s[c][7:0]; a1 = s[c][15:8]; a2 = s[c][23:16]; a3 = s[c][31:24];
        if (!inv) begin
          t[c][7:0]   = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
          t[c][15:8]  = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
          t[c][23:16] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
          t[c][31:24] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
        end else begin
          t[c][7:0]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
          t[c][15:8]  = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
          t[c][23:16] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
          t[c][31:24] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
        end
      end
      return t;
    endfunction

    function block_t add_key(block_t s, int rnd);
      for (int c = 0; c < 4; c++) s[c] ^= key_mem[rnd*4 + c];
      return s;
    endfunction

    function block_t cipher(block_t s, bit inv);
      int nr;
      nr = rounds < aes_pkg::ROUNDS_MIN ? aes_pkg::ROUNDS_MIN :
           (rounds > aes_pkg::ROUNDS_MAX ? aes_pkg::ROUNDS_MAX : rounds);
      if (!inv) begin
        s = add_key(s, 0);
        for (int r = 1; r < nr; r++) s = add_key(mix(sub_shift(s, 0), 0), r);
        s = add_key(sub_shift(s, 0), nr);
      end else begin
        s = add_key(s, nr);
        for (int r = nr - 1; r > 0; r--) s = add_key(mix(sub_shift(s, 1), 1), r);
        s = add_key(sub_shift(s, 1), 0);
      end
      return s;
    endfunction

    function void note_word(aes_pkg::cmd_t cmd, logic [5:0] idx, logic [31:0] kw,
                            block_t blk);
      case (cmd)
        aes_pkg::CMD_KEY: if (idx < aes_pkg::KEY_STORE_WORDS) key_mem[idx] = kw;
        aes_pkg::CMD_ENC: expected_blocks.push_back(cipher(blk, 0));
        aes_pkg::CMD_DEC: expected_blocks.push_back(cipher(blk, 1));
        default: ;
      endcase
    endfunction

    function void check_word(block_t got);
      block_t exp_blk;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_blk = expected_blocks.pop_front();
      checked++;
      for (int c = 0; c < 4; c++)
        if (got[c] !== exp_blk[c]) begin
          $display("%0t: out_word%0d expected %h got %h", $time, c, exp_blk[c], got[c]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_num_rounds = 4'd10;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = aes_pkg::CMD_NOP;
  logic [5:0] in_key_index = '0;
  logic [31:0] in_key_word = '0;
  logic [31:0] in_block_word0 = '0, in_block_word1 = '0, in_block_word2 = '0;
  logic [31:0] in_block_word3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_word0, out_word1, out_word2, out_word3;

  block_predictor pred = new();
  bit hold_pending = 0;
  int idle_cycles = 0;
  int enc_count = 0, dec_count = 0, key_count = 0;

  always #4 clk = ~clk;

  aes_block_cipher_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_num_rounds(cfg_num_rounds),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_key_index(in_key_index), .in_key_word(in_key_word),
    .in_block_word0(in_block_word0), .in_block_word1(in_block_word1),
    .in_block_word2(in_block_word2), .in_block_word3(in_block_word3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_word0(out_word0), .out_word1(out_word1),
    .out_word2(out_word2), .out_word3(out_word3)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pred.check_word({out_word3, out_word2, out_word1, out_word0});
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = hold_pending ? 300 : $urandom_range(0, 3);
      hold_pending = 0;
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_word(aes_pkg::cmd_t cmd, logic [5:0] idx, logic [31:0] kw,
                           block_t blk);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key_index <= idx;
    in_key_word <= kw;
    {in_block_word3, in_block_word2, in_block_word1, in_block_word0} <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred.note_word(cmd, idx, kw, blk);
    case (cmd)
      aes_pkg::CMD_KEY: key_count++;
      aes_pkg::CMD_ENC: enc_count++;
      aes_pkg::CMD_DEC: dec_count++;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.expected_blocks.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_rounds(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_num_rounds <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred.rounds = v;
  endtask

  function automatic block_t rand_block();
    block_t b;
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = '1;
      default: b = {$urandom, $urandom, $urandom, $urandom};
    endcase
    return b;
  endfunction

  initial begin
    logic [3:0] settings [8];
    int sel;
    aes_pkg::cmd_t cmd;
    settings = '{4'd10, 4'd12, 4'd14, 4'd0, 4'd15, 4'd11, 4'd13, 4'd9};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // load the whole key store first so no unwritten word is ever read
    for (int i = 0; i < aes_pkg::KEY_STORE_WORDS; i++)
      send_word(aes_pkg::CMD_KEY, 6'(i),
                (i == 0) ? 32'h0 : (i == 59) ? 32'hffffffff : $urandom, rand_block());
    send_word(aes_pkg::CMD_KEY, 6'd60, $urandom, '1);
    send_word(aes_pkg::CMD_KEY, 6'd63, 32'hffffffff, '0);
    send_word(aes_pkg::CMD_NOP, 6'd63, 32'hffffffff, '1);
    send_word(aes_pkg::CMD_ENC, 6'd0, 32'h0, '0);
    send_word(aes_pkg::CMD_ENC, 6'd63, 32'hffffffff, '1);
    send_word(aes_pkg::CMD_DEC, 6'd0, 32'h0, '0);
    send_word(aes_pkg::CMD_DEC, 6'd63, 32'hffffffff, '1);
    send_word(aes_pkg::CMD_ENC, 6'd0, 32'h0, 128'h00112233_44556677_8899aabb_ccddeeff);
    send_word(aes_pkg::CMD_DEC, 6'd0, 32'h0, 128'h00112233_44556677_8899aabb_ccddeeff);
    for (int p = 0; p < 8; p++) begin
      set_rounds(settings[p]);
      if (p == 1) hold_pending = 1;
      for (int k = 0; k < 135; k++) begin
        sel = $urandom_range(0, 99);
        cmd = sel < 40 ? aes_pkg::CMD_ENC : sel < 80 ? aes_pkg::CMD_DEC :
              sel < 95 ? aes_pkg::CMD_KEY : aes_pkg::CMD_NOP;
        send_word(cmd, 6'($urandom_range(0, 63)), $urandom, rand_block());
      end
    end
    drain();
    $display("covered %0d encrypt, %0d decrypt and %0d key words, %0d blocks checked",
             enc_count, dec_count, key_count, pred.checked);
    $display("round settings 10..14 plus out-of-range 0, 9 and 15, with output stalls");
    if (pred.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> files.f
src/aes_pkg.sv
src/aes_round.sv
src/aes_block_cipher_core.sv
src/aes_core_checker.sv
bench/tb.sv
